@@ rtl/pilw_pkg.sv @@
package pilw_pkg;

    localparam int unsigned IdWidth = 63;

    typedef logic [IdWidth-1:0] id_t;

    // Request codes. Any other code behaves like a probe.
    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_RESOLVE = 2'd1;
    localparam logic [1:0] REQ_PROBE   = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_RES  = 4'b1000
    } state_t;

    // Commands from the sequencer to the row of cells.
    typedef struct packed {
        logic compare;
        logic apply_add;
        logic apply_resolve;
    } chain_cmd_t;

    // Commands that every cell sees.
    typedef struct packed {
        logic compare;
        logic insert;
        logic remove;
    } cell_cmd_t;

    // Status from the row of cells back to the sequencer.
    typedef struct packed {
        logic any_eq;
        logic full;
        logic head_valid;
        id_t  head_id;
    } chain_stat_t;

endpackage

@@ rtl/pilw_cell.sv @@
// One slot of the sorted row. Valid slots are packed at the low end and
// hold their ids in ascending order.
module pilw_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pilw_pkg::cell_cmd_t  cmd,
    input  pilw_pkg::id_t        key,
    input  logic                 left_lt,
    input  logic                 left_valid,
    input  pilw_pkg::id_t        left_id,
    input  logic                 right_valid,
    input  pilw_pkg::id_t        right_id,
    output logic                 valid,
    output pilw_pkg::id_t        id,
    output logic                 lt,
    output logic                 eq
);

    logic          valid_reg;
    logic          valid_next;
    pilw_pkg::id_t id_reg;
    pilw_pkg::id_t id_next;
    logic          lt_reg;
    logic          eq_reg;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        if (cmd.insert && !lt_reg) begin
            // The first slot whose id is above the key, or the first free slot if
            // there is none, takes the key; every slot above it shifts up by one.
            if (left_lt) begin
                valid_next = 1'b1;
                id_next    = key;
            end else begin
                valid_next = left_valid;
                id_next    = left_id;
            end
        end else if (cmd.remove && !lt_reg) begin
            valid_next = right_valid;
            id_next    = right_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.compare) begin
                lt_reg <= valid_reg && (id_reg < key);
                eq_reg <= valid_reg && (id_reg == key);
            end
        end
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

@@ rtl/pilw_chain.sv @@
// Row of cells with the neighbor links, the match reduction and the
// decision whether the pending add or resolve really changes the set.
module pilw_chain #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pilw_pkg::chain_cmd_t  cmd,
    input  pilw_pkg::id_t         key,
    output pilw_pkg::chain_stat_t stat
);

    logic [CAPACITY-1:0] valid_w;
    logic [CAPACITY-1:0] lt_w;
    logic [CAPACITY-1:0] eq_w;
    pilw_pkg::id_t       id_w [CAPACITY];
    logic                any_eq;
    logic                full;
    pilw_pkg::cell_cmd_t cell_cmd;

    assign any_eq = |eq_w;
    assign full   = valid_w[CAPACITY-1];

    always_comb begin
        cell_cmd.compare = cmd.compare;
        cell_cmd.insert  = cmd.apply_add && !any_eq && !full;
        cell_cmd.remove  = cmd.apply_resolve && any_eq;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic          left_lt;
        logic          left_valid;
        pilw_pkg::id_t left_id;
        logic          right_valid;
        pilw_pkg::id_t right_id;

        if (i == 0) begin : g_left_end
            assign left_lt    = 1'b1;
            assign left_valid = 1'b0;
            assign left_id    = '0;
        end else begin : g_left
            assign left_lt    = lt_w[i-1];
            assign left_valid = valid_w[i-1];
            assign left_id    = id_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_right_end
            assign right_valid = 1'b0;
            assign right_id    = '0;
        end else begin : g_right
            assign right_valid = valid_w[i+1];
            assign right_id    = id_w[i+1];
        end

        pilw_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cell_cmd),
            .key         (key),
            .left_lt     (left_lt),
            .left_valid  (left_valid),
            .left_id     (left_id),
            .right_valid (right_valid),
            .right_id    (right_id),
            .valid       (valid_w[i]),
            .id          (id_w[i]),
            .lt          (lt_w[i]),
            .eq          (eq_w[i])
        );
    end

    always_comb begin
        stat.any_eq     = any_eq;
        stat.full       = full;
        stat.head_valid = valid_w[0];
        stat.head_id    = id_w[0];
    end

endmodule

@@ rtl/pending_id_low_watermark.sv @@
// Tracker for record ids that are still in flight. Each request adds an id,
// resolves an id or only probes, and yields exactly one result: the committed
// watermark (lowest pending id minus one, or the highest id ever added when
// nothing is pending), the lowest pending id, an empty flag, whether the
// request's id is the lowest pending one, and an overflow flag for an add that
// found all CAPACITY slots taken. The pending ids live in a row of CAPACITY
// cells that keep them sorted in ascending order, so the lowest id is always
// in the first cell; an add shifts the higher ids up by one cell and a
// resolve shifts them down, each cell moving data only to its neighbor.
// A request passes through these steps in order: it is accepted and latched
// while the block is idle, every cell compares its id against it, the row is
// updated in one shift, and the result is formed from the head cell and
// loaded into the result register. The block takes no new request until it
// is idle again after the result step. A new request is accepted while the
// previous result still waits in the output register; the result step holds
// only if that register is still full.
module pending_id_low_watermark #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [62:0]           s_record_id,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [62:0]           m_committed_mark,
    output logic [62:0]           m_lowest_pending,
    output logic                  m_none_pending,
    output logic                  m_is_first_hidden,
    output logic                  m_overflow
);

    pilw_pkg::state_t      state_reg;
    pilw_pkg::state_t      state_next;
    logic [1:0]            req_reg;
    pilw_pkg::id_t         key_reg;
    pilw_pkg::id_t         highest_reg;
    logic                  ovf_reg;
    logic                  m_valid_reg;
    pilw_pkg::id_t         mark_reg;
    pilw_pkg::id_t         lowest_reg;
    logic                  none_reg;
    logic                  first_reg;
    logic                  m_ovf_reg;

    pilw_pkg::chain_cmd_t  chain_cmd;
    pilw_pkg::chain_stat_t chain_stat;
    logic                  req_is_add;
    logic                  add_taken;
    logic                  add_dropped;
    logic                  load_result;

    assign req_is_add  = (req_reg == pilw_pkg::REQ_ADD);
    // An add is stored only if the id is new and a slot is free. A
    // duplicate add is silent even when the set is full.
    assign add_taken   = req_is_add && !chain_stat.any_eq && !chain_stat.full;
    assign add_dropped = req_is_add && !chain_stat.any_eq && chain_stat.full;

    always_comb begin
        chain_cmd.compare       = (state_reg == pilw_pkg::ST_CMP);
        chain_cmd.apply_add     = (state_reg == pilw_pkg::ST_UPD) && req_is_add;
        chain_cmd.apply_resolve = (state_reg == pilw_pkg::ST_UPD)
                                  && (req_reg == pilw_pkg::REQ_RESOLVE);
    end

    pilw_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (chain_cmd),
        .key     (key_reg),
        .stat    (chain_stat)
    );

    assign s_ready     = (state_reg == pilw_pkg::ST_IDLE);
    assign load_result = (state_reg == pilw_pkg::ST_RES) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pilw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pilw_pkg::ST_CMP;
                end
            end
            pilw_pkg::ST_CMP: begin
                state_next = pilw_pkg::ST_UPD;
            end
            pilw_pkg::ST_UPD: begin
                state_next = pilw_pkg::ST_RES;
            end
            pilw_pkg::ST_RES: begin
                if (load_result) begin
                    state_next = pilw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pilw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pilw_pkg::ST_IDLE;
            highest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == pilw_pkg::ST_UPD) && add_taken && (key_reg > highest_reg)) begin
                highest_reg <= key_reg;
            end
            if (load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req_type;
            key_reg <= s_record_id;
        end
        if (state_reg == pilw_pkg::ST_UPD) begin
            ovf_reg <= add_dropped;
        end
        if (load_result) begin
            // When the head id is zero the mark wraps to all ones.
            mark_reg   <= chain_stat.head_valid ? (chain_stat.head_id - 63'd1) : highest_reg;
            lowest_reg <= chain_stat.head_valid ? chain_stat.head_id : '0;
            none_reg   <= !chain_stat.head_valid;
            first_reg  <= chain_stat.head_valid && (chain_stat.head_id == key_reg);
            m_ovf_reg  <= ovf_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_committed_mark  = mark_reg;
    assign m_lowest_pending  = lowest_reg;
    assign m_none_pending    = none_reg;
    assign m_is_first_hidden = first_reg;
    assign m_overflow        = m_ovf_reg;

endmodule

@@ tb/tb_pending_id_low_watermark.sv @@
`timescale 1ns / 100ps

module tb_pending_id_low_watermark;

    // Request code 3 is not defined. The block must treat it as a probe.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int unsigned SLOTS       = 16;
    localparam int unsigned MAX_GAP     = 15;
    // This margin gives any unexpected result still in flight time to show up
    // after the last expectation has been consumed.
    localparam int unsigned DRAIN_WAIT  = 8;
    // The slowest legal run is about 1300 requests, each with the longest send
    // gap, its pass through the block and the longest receive stall, so this
    // limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT = 400_000;

    // One expected result, with the same fields as the result channel.
    typedef struct packed {
        pilw_pkg::id_t committed_mark;
        pilw_pkg::id_t lowest_pending;
        logic          none_pending;
        logic          is_first_hidden;
        logic          overflow;
    } watermark_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_req_type;
    logic [62:0] s_record_id;
    logic m_valid;
    logic m_ready;
    logic [62:0] m_committed_mark;
    logic [62:0] m_lowest_pending;
    logic m_none_pending;
    logic m_is_first_hidden;
    logic m_overflow;

    // Our own copy of the tracked set. Slot order does not change any output,
    // but the set is filled lowest free slot first, unlike the sorted row in
    // the block.
    pilw_pkg::id_t slot_id [SLOTS];
    logic          slot_used [SLOTS];
    pilw_pkg::id_t top_id;

    // Predicted results, oldest first.
    watermark_t expected_marks[$];
    watermark_t want;

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    // When set, neither the sender nor the receiver inserts idle cycles.
    bit no_gaps = 1'b0;

    always #6 aclk = ~aclk;

    pending_id_low_watermark #(
        .CAPACITY(SLOTS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_record_id       (s_record_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_committed_mark  (m_committed_mark),
        .m_lowest_pending  (m_lowest_pending),
        .m_none_pending    (m_none_pending),
        .m_is_first_hidden (m_is_first_hidden),
        .m_overflow        (m_overflow)
    );

    // Applies one accepted request to the tracked set and returns the result
    // the block must report for it.
    function automatic watermark_t predict_watermark(input logic [1:0] req,
                                                     input pilw_pkg::id_t id);
        watermark_t    res;
        int            hit;
        int            free;
        logic          any;
        pilw_pkg::id_t lowest;
        hit    = -1;
        free   = -1;
        any    = 1'b0;
        lowest = '0;
        res    = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_id[i] == id && hit < 0) begin
                hit = i;
            end
            if (!slot_used[i] && free < 0) begin
                free = i;
            end
        end
        if (req == pilw_pkg::REQ_ADD && hit < 0) begin
            // A full set drops the add, and the highest id seen stays as it was.
            if (free < 0) begin
                res.overflow = 1'b1;
            end else begin
                slot_id[free]   = id;
                slot_used[free] = 1'b1;
                if (id > top_id) begin
                    top_id = id;
                end
            end
        end else if (req == pilw_pkg::REQ_RESOLVE && hit >= 0) begin
            slot_used[hit] = 1'b0;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && (!any || slot_id[i] < lowest)) begin
                lowest = slot_id[i];
                any    = 1'b1;
            end
        end
        // A pending id of zero makes the watermark wrap to all ones within
        // 63 bits. The empty flag is what tells that apart from an empty set.
        res.committed_mark  = any ? pilw_pkg::id_t'(lowest - 1'b1) : top_id;
        res.lowest_pending  = any ? lowest : '0;
        res.none_pending    = !any;
        res.is_first_hidden = any && (lowest == id);
        return res;
    endfunction

    // Narrow ids stay small so that the highest id seen keeps moving for a
    // while. Wide ids exercise every bit of the 63-bit field.
    function automatic pilw_pkg::id_t random_id(input bit wide);
        pilw_pkg::id_t id;
        if (wide && $urandom_range(0, 3) != 0) begin
            id = pilw_pkg::id_t'({$urandom(), $urandom()});
        end else begin
            id = pilw_pkg::id_t'($urandom_range(0, 40));
        end
        return id;
    endfunction

    // Picks one of the ids that are pending right now, or a random id when
    // the set is empty.
    function automatic pilw_pkg::id_t pick_pending(input bit wide);
        int used[$];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
                used.push_back(i);
            end
        end
        if (used.size() == 0) begin
            return random_id(wide);
        end
        return slot_id[used[$urandom_range(0, used.size() - 1)]];
    endfunction

    // Sends one request. The valid line is lowered only for a real gap, so it
    // gets at most one assignment in any time step. The prediction is made at
    // the edge that accepts the request.
    task automatic send_request(input logic [1:0] req, input pilw_pkg::id_t id);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_record_id <= id;
        do @(posedge aclk); while (!s_ready);
        expected_marks.push_back(predict_watermark(req, id));
    endtask

    // Holds the sender off until every outstanding request has produced its
    // result. A request was just accepted, so the loop always advances time
    // before the next request can raise valid again.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_marks.size() != 0) @(posedge aclk);
    endtask

    // Empty-set behavior, the unused request code, duplicates, a resolve of
    // an absent id, and an id of zero as the lowest pending one.
    task automatic test_basic_requests();
        send_request(pilw_pkg::REQ_PROBE, pilw_pkg::id_t'(0));
        send_request(REQ_UNUSED, pilw_pkg::id_t'(3));
        send_request(pilw_pkg::REQ_RESOLVE, pilw_pkg::id_t'(5));
        send_request(pilw_pkg::REQ_ADD, pilw_pkg::id_t'(1));
        send_request(pilw_pkg::REQ_ADD, pilw_pkg::id_t'(1));
        send_request(pilw_pkg::REQ_PROBE, pilw_pkg::id_t'(1));
        send_request(pilw_pkg::REQ_ADD, pilw_pkg::id_t'(0));
        send_request(pilw_pkg::REQ_PROBE, pilw_pkg::id_t'(0));
        send_request(pilw_pkg::REQ_RESOLVE, pilw_pkg::id_t'(0));
        send_request(pilw_pkg::REQ_RESOLVE, pilw_pkg::id_t'(1));
    endtask

    // Fills every slot, then checks that a new id overflows while a
    // duplicate of a stored id does not. The sender then waits until every
    // result is back before anything else is sent.
    task automatic test_full_set();
        for (int i = 2; i < 2 + SLOTS; i++) begin
            send_request(pilw_pkg::REQ_ADD, pilw_pkg::id_t'(i));
        end
        send_request(pilw_pkg::REQ_ADD, pilw_pkg::id_t'(40));
        send_request(pilw_pkg::REQ_ADD, pilw_pkg::id_t'(9));
        wait_all_results();
    endtask

    // Random traffic. Adds slightly outnumber resolves, so the set keeps
    // hitting full, while most resolves and half of the probes name ids that really are
    // pending. Stretches without idling on either side are mixed in.
    task automatic test_random_traffic(input int unsigned count, input bit wide);
        int unsigned   pick;
        pilw_pkg::id_t id;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (n == count / 2) begin
                wait_all_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                id = ($urandom_range(0, 4) == 0) ? pick_pending(wide) : random_id(wide);
                send_request(pilw_pkg::REQ_ADD, id);
            end else if (pick < 85) begin
                id = ($urandom_range(0, 3) != 0) ? pick_pending(wide) : random_id(wide);
                send_request(pilw_pkg::REQ_RESOLVE, id);
            end else if (pick < 95) begin
                id = ($urandom_range(0, 1) != 0) ? pick_pending(wide) : random_id(wide);
                send_request(pilw_pkg::REQ_PROBE, id);
            end else begin
                send_request(REQ_UNUSED, pick_pending(wide));
            end
        end
        no_gaps = 1'b0;
    endtask

    // The largest id is added last because it pins the highest id seen for
    // the rest of the run.
    task automatic test_extreme_ids();
        send_request(pilw_pkg::REQ_ADD, '1);
        send_request(pilw_pkg::REQ_PROBE, '1);
        send_request(REQ_UNUSED, '1);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
                send_request(pilw_pkg::REQ_RESOLVE, slot_id[i]);
            end
        end
        send_request(pilw_pkg::REQ_PROBE, '1);
    endtask

    // Main sequence: reset once, then each test in turn, then the verdict.
    initial begin
        s_valid     <= 1'b0;
        s_req_type  <= pilw_pkg::REQ_PROBE;
        s_record_id <= '0;
        aresetn     <= 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_id[i]   = '0;
            slot_used[i] = 1'b0;
        end
        top_id = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_requests();
        test_full_set();
        test_random_traffic(600, 1'b0);
        test_random_traffic(620, 1'b1);
        test_extreme_ids();

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Result side: a fresh stall is drawn for every result, and ready then
    // stays high until a result is taken.
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic check_field(input string field, input pilw_pkg::id_t exp_val,
                               input pilw_pkg::id_t got_val);
        if (exp_val !== got_val) begin
            $display("%0t ns: %s expected %h, got %h", $time, field, exp_val, got_val);
            mismatches++;
        end
    endtask

    // Every result taken is compared against the oldest prediction. Values
    // are read at the clock edge, before any update from that edge lands.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_marks.size() == 0) begin
                $display("%0t ns: result expected none, got mark %h", $time,
                         m_committed_mark);
                mismatches++;
            end else begin
                want = expected_marks.pop_front();
                check_field("committed_mark", want.committed_mark, m_committed_mark);
                check_field("lowest_pending", want.lowest_pending, m_lowest_pending);
                check_field("none_pending", pilw_pkg::id_t'(want.none_pending),
                            pilw_pkg::id_t'(m_none_pending));
                check_field("is_first_hidden", pilw_pkg::id_t'(want.is_first_hidden),
                            pilw_pkg::id_t'(m_is_first_hidden));
                check_field("overflow", pilw_pkg::id_t'(want.overflow),
                            pilw_pkg::id_t'(m_overflow));
            end
        end
    end

    // Guards against a stuck handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
